// File: hdl/aescfb_pkg.sv
// Shared constants, register codes and AES round functions for the CFB8 byte cipher.
// No dependencies; used by aes128_cfb8_byte_cipher.
`default_nettype none
package aescfb_pkg;

	localparam int unsigned ROUNDS = 10;
	localparam int unsigned KEY_BITS = 128;

	typedef logic [KEY_BITS-1:0] block_t;
	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t CFG_KEY_HIGH = 3'd0;
	localparam cfg_index_t CFG_KEY_LOW = 3'd1;
	localparam cfg_index_t CFG_IV_HIGH = 3'd2;
	localparam cfg_index_t CFG_IV_LOW = 3'd3;
	localparam cfg_index_t CFG_DECRYPT = 3'd4;

	localparam logic [7:0] RCON_FIRST = 8'h01;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// SubBytes and ShiftRows; byte i sits at bits [127-8i -: 8]
	function automatic block_t sub_shift(input block_t s);
		block_t t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
			end
		end
		return t;
	endfunction

	// MixColumns over the four columns
	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			b0 = xtime(a0);
			b1 = xtime(a1);
			b2 = xtime(a2);
			b3 = xtime(a3);
			t[127-32*c -: 8] = b0 ^ a1 ^ b1 ^ a2 ^ a3;
			t[119-32*c -: 8] = a0 ^ b1 ^ a2 ^ b2 ^ a3;
			t[111-32*c -: 8] = a0 ^ a1 ^ b2 ^ a3 ^ b3;
			t[103-32*c -: 8] = a0 ^ b0 ^ a1 ^ a2 ^ b3;
		end
		return t;
	endfunction

	// Derive the next 128-bit round key from the current one
	function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
		logic [31:0] t, n0, n1, n2, n3;
		t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		n0 = k[127:96] ^ t;
		n1 = k[95:64] ^ n0;
		n2 = k[63:32] ^ n1;
		n3 = k[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage
`default_nettype wire

// File: hdl/aescfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module aescfb_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/aes128_cfb8_byte_cipher.sv
// Top level of the AES-128 CFB8 byte cipher: sequencer, round datapath, feedback.
// Depends on aescfb_pkg and aescfb_ram (round-key store).
//
//  channel | signals                                   | direction
//  input   | in_valid, in_ready, data_in, start_of_message | in (word: one byte)
//  output  | out_valid, out_ready, data_out            | out (word: one byte)
//  config  | cfg_we, cfg_index, cfg_data               | in, no handshake
//
// A word passes from accept to result through one key-store read, eleven round
// steps of the shared round unit (one per cycle) and a finish step.
// A start of message adds key expansion first, one round key per cycle.
// in_ready is high only while the sequencer is idle; a finished word waits in
// the finish state if the output register is still full.
// Reset clears the feedback register and the configuration registers.
`default_nettype none
module aes128_cfb8_byte_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_in,
	input  wire logic        start_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  data_out,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_RDKEY  = 3'd2;
	localparam logic [2:0] ST_ROUND  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	localparam logic [3:0] LAST_ROUND = 4'(aescfb_pkg::ROUNDS);

	logic [2:0]  state_q;
	logic [3:0]  cnt_q;
	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic        decrypt_q;
	aescfb_pkg::block_t fb_q, blk_q, rkey_q, rk_rdata, round_in;
	logic [7:0]  rc_q, din_q, dout_next, fed;
	logic        out_valid_q;
	logic [7:0]  data_out_q;
	logic [3:0]  rd_addr;
	logic        in_acc, finish_go;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Round-key store, one 128-bit round key per entry
	assign rd_addr = (state_q == ST_RDKEY || cnt_q == LAST_ROUND) ? 4'(0) : cnt_q + 4'd1;

	aescfb_ram #(
		.WIDTH(aescfb_pkg::KEY_BITS),
		.DEPTH(aescfb_pkg::ROUNDS + 1)
	) u_rk_ram (
		.clk   (clk),
		.we    (state_q == ST_EXPAND),
		.waddr (cnt_q),
		.wdata (rkey_q),
		.raddr (rd_addr),
		.rdata (rk_rdata)
	);

	// Shared round unit: whitening on round zero, no mixing on the last round
	always_comb begin
		if (cnt_q == 4'd0) begin
			round_in = fb_q;
		end else if (cnt_q == LAST_ROUND) begin
			round_in = aescfb_pkg::sub_shift(blk_q);
		end else begin
			round_in = aescfb_pkg::mix_columns(aescfb_pkg::sub_shift(blk_q));
		end
	end

	assign dout_next = din_q ^ blk_q[127:120];
	assign fed       = decrypt_q ? din_q : dout_next;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			decrypt_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aescfb_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				aescfb_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
				aescfb_pkg::CFG_IV_HIGH:  iv_high_q  <= cfg_data;
				aescfb_pkg::CFG_IV_LOW:   iv_low_q   <= cfg_data;
				aescfb_pkg::CFG_DECRYPT:  decrypt_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, feedback register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished word, or drop the taken one
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						if (start_of_message) begin
							fb_q    <= {iv_high_q, iv_low_q};
							state_q <= ST_EXPAND;
						end else begin
							state_q <= ST_RDKEY;
						end
					end
				end
				ST_EXPAND: begin
					if (cnt_q == LAST_ROUND) begin
						cnt_q   <= '0;
						state_q <= ST_RDKEY;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_RDKEY: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (cnt_q == LAST_ROUND) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						fb_q    <= {fb_q[119:0], fed};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: input byte, key schedule, cipher state, result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			din_q <= data_in;
			if (start_of_message) begin
				rkey_q <= {key_high_q, key_low_q};
				rc_q   <= aescfb_pkg::RCON_FIRST;
			end
		end
		if (state_q == ST_EXPAND) begin
			rkey_q <= aescfb_pkg::next_round_key(rkey_q, rc_q);
			rc_q   <= aescfb_pkg::xtime(rc_q);
		end
		if (state_q == ST_ROUND) begin
			blk_q <= round_in ^ rk_rdata;
		end
		if (finish_go) begin
			data_out_q <= dout_next;
		end
	end

`ifndef ASSERT_OFF
	a_som_expands: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && start_of_message |=> state_q == ST_EXPAND)
		else $error("start of message did not begin key expansion");
	a_plain_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !start_of_message |=> state_q == ST_RDKEY)
		else $error("word did not go straight to key read");
	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && cnt_q == LAST_ROUND |=> state_q == ST_FINISH)
		else $error("last round did not finish");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |-> !out_valid_q || out_ready)
		else $error("result overwrote a pending word");
`endif

endmodule
`default_nettype wire
